### rtl/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types, constants and the arctangent table for the point transform.
// ----------------------------------------------------------------------------
package pat_pkg;

    localparam int COORD_WIDTH           = 32;
    localparam int FRAC_BITS             = 16;
    localparam int ID_W                  = 16;
    localparam int ANGLE_W               = 16;
    localparam int CORDIC_STEPS_DEFAULT  = 16;
    localparam int ATAN_ENTRIES          = 24;
    localparam int ATAN_IDX_W            = 5;
    localparam int TRIG_W                = 32;
    localparam int TRIG_FRAC             = 30;
    localparam int ZW                    = 32;
    localparam int CFG_IDX_W             = 3;
    localparam int CFG_DATA_W            = 32;

    // datapath widths: differences, coefficients, products, sums, final
    localparam int DW = COORD_WIDTH + 1;
    localparam int KW = (DW > TRIG_W) ? DW : TRIG_W;
    localparam int PW = DW + KW;
    localparam int SW = PW + 1;
    localparam int FW = SW + 1;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sh26DD3B6A;

    typedef enum logic [1:0] {
        MODE_TRANSLATE = 2'd0,
        MODE_ROTATE    = 2'd1,
        MODE_SCALE     = 2'd2,
        MODE_MAP       = 2'd3
    } pat_mode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SETUP_ERR = 2'd1,
        STATUS_SAT       = 2'd2
    } pat_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 3'd0,
        CFG_FIRST_X = 3'd1,
        CFG_FIRST_Y = 3'd2,
        CFG_ANGLE   = 3'd3,
        CFG_PIVOT_X = 3'd4,
        CFG_PIVOT_Y = 3'd5,
        CFG_END_X   = 3'd6,
        CFG_END_Y   = 3'd7
    } pat_cfg_idx_t;

    typedef struct packed {
        logic [ID_W-1:0]               point_id;
        logic signed [COORD_WIDTH-1:0] x_in;
        logic signed [COORD_WIDTH-1:0] y_in;
    } pat_in_t;

    typedef struct packed {
        logic [ID_W-1:0]               id_out;
        logic signed [COORD_WIDTH-1:0] x_out;
        logic signed [COORD_WIDTH-1:0] y_out;
        pat_status_t                   status;
    } pat_out_t;

    typedef struct packed {
        pat_mode_t                     mode;
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] pivot_x;
        logic signed [COORD_WIDTH-1:0] pivot_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
    } pat_cfg_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_val;
        logic signed [TRIG_W-1:0] sin_val;
    } pat_trig_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [ZW-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ZW-1:0] v;
        begin
            case (idx)
                5'd0:    v = 32'sh20000000;
                5'd1:    v = 32'sh12E4051E;
                5'd2:    v = 32'sh09FB385B;
                5'd3:    v = 32'sh051111D4;
                5'd4:    v = 32'sh028B0D43;
                5'd5:    v = 32'sh0145D7E1;
                5'd6:    v = 32'sh00A2F61E;
                5'd7:    v = 32'sh00517C55;
                5'd8:    v = 32'sh0028BE53;
                5'd9:    v = 32'sh00145F2F;
                5'd10:   v = 32'sh000A2F98;
                5'd11:   v = 32'sh000517CC;
                5'd12:   v = 32'sh00028BE6;
                5'd13:   v = 32'sh000145F3;
                5'd14:   v = 32'sh0000A2FA;
                5'd15:   v = 32'sh0000517D;
                5'd16:   v = 32'sh000028BE;
                5'd17:   v = 32'sh0000145F;
                5'd18:   v = 32'sh00000A30;
                5'd19:   v = 32'sh00000518;
                5'd20:   v = 32'sh0000028C;
                5'd21:   v = 32'sh00000146;
                5'd22:   v = 32'sh000000A3;
                5'd23:   v = 32'sh00000051;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

### rtl/point_affine_transform_unit.sv
// ----------------------------------------------------------------------------
// point_affine_transform_unit
// Translate, rotate, scale or segment-map of Q16.16 points with saturation.
// ----------------------------------------------------------------------------
// A point is taken on every clock edge with start high and busy low, and its
// result appears on result with done high for exactly one cycle, after it has
// passed the three-stage pipeline (offsets and coefficients, four parallel
// multipliers, round and saturate); one point per cycle is sustained while
// busy is low. The receiver cannot stall, so results must be captured when
// done is high. After reset and after every write of rotation_angle, busy
// stays high while the single shared CORDIC stage iterates to the new cosine
// and sine; other register writes cost nothing. The user must write registers
// only while no transaction is in flight; the block does not enforce this.
module point_affine_transform_unit
    import pat_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pat_in_t               point,
    output logic                  done,
    output pat_out_t              result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pat_cfg_t  cfg_reg, cfg_next;
    pat_trig_t trig;
    logic      accept;
    logic      angle_load;

    assign accept     = start && !busy;
    assign angle_load = cfg_we && (cfg_index == CFG_ANGLE);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (pat_cfg_idx_t'(cfg_index))
                CFG_MODE:    cfg_next.mode    = pat_mode_t'(cfg_data[1:0]);
                CFG_FIRST_X: cfg_next.first_x = cfg_data[COORD_WIDTH-1:0];
                CFG_FIRST_Y: cfg_next.first_y = cfg_data[COORD_WIDTH-1:0];
                CFG_PIVOT_X: cfg_next.pivot_x = cfg_data[COORD_WIDTH-1:0];
                CFG_PIVOT_Y: cfg_next.pivot_y = cfg_data[COORD_WIDTH-1:0];
                CFG_END_X:   cfg_next.end_x   = cfg_data[COORD_WIDTH-1:0];
                CFG_END_Y:   cfg_next.end_y   = cfg_data[COORD_WIDTH-1:0];
                default:     cfg_next         = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pat_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (angle_load),
        .angle (cfg_data[ANGLE_W-1:0]),
        .busy  (busy),
        .trig  (trig)
    );

    pat_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .point  (point),
        .cfg    (cfg_reg),
        .trig   (trig),
        .done   (done),
        .result (result)
    );

    // every accepted transaction returns exactly one result on done
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted transaction produced no result");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result without an accepted transaction");

    // the trig sequencer restarts only on an angle write
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(cfg_we && (cfg_index == CFG_ANGLE)))
        else $error("busy rose without an angle write");

    // a setup error reports a zero point
    a_setup_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == STATUS_SETUP_ERR)) |->
        ((result.x_out == '0) && (result.y_out == '0)))
        else $error("setup error with nonzero coordinates");

endmodule

### rtl/pat_cordic.sv
// ----------------------------------------------------------------------------
// pat_cordic
// Iterative CORDIC producing cosine and sine in Q2.30 for the rotation angle.
// ----------------------------------------------------------------------------
module pat_cordic
    import pat_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [ANGLE_W-1:0] angle,
    output logic               busy,
    output pat_trig_t          trig
);

    localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int STEP_W = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);

    logic                     running_reg, running_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [TRIG_W-1:0] x_reg, x_next;
    logic signed [TRIG_W-1:0] y_reg, y_next;
    logic signed [ZW-1:0]     z_reg, z_next;
    logic                     flip_reg, flip_next;
    pat_trig_t                trig_reg, trig_next;

    logic [ANGLE_W-1:0]       folded;
    logic                     flip_in;
    logic signed [TRIG_W-1:0] x_sh, y_sh, x_it, y_it;
    logic signed [ZW-1:0]     at, z_it;

    always_comb
    begin
        // second and third quadrant: rotate by angle - half turn, negate at the end
        flip_in = (angle[ANGLE_W-1:ANGLE_W-2] == 2'b01) || (angle[ANGLE_W-1:ANGLE_W-2] == 2'b10);
        folded  = flip_in ? (angle - ANGLE_W'(1 << (ANGLE_W - 1))) : angle;

        x_sh = x_reg >>> step_reg;
        y_sh = y_reg >>> step_reg;
        at   = atan_turn(ATAN_IDX_W'(step_reg));
        if (!z_reg[ZW-1])
        begin
            x_it = x_reg - y_sh;
            y_it = y_reg + x_sh;
            z_it = z_reg - at;
        end
        else
        begin
            x_it = x_reg + y_sh;
            y_it = y_reg - x_sh;
            z_it = z_reg + at;
        end

        running_next = running_reg;
        step_next    = step_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        flip_next    = flip_reg;
        trig_next    = trig_reg;

        if (load)
        begin
            running_next = 1'b1;
            step_next    = '0;
            x_next       = CORDIC_GAIN;
            y_next       = '0;
            z_next       = {folded, {(ZW - ANGLE_W){1'b0}}};
            flip_next    = flip_in;
        end
        else if (running_reg)
        begin
            x_next    = x_it;
            y_next    = y_it;
            z_next    = z_it;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP)
            begin
                running_next      = 1'b0;
                trig_next.cos_val = flip_reg ? -x_it : x_it;
                trig_next.sin_val = flip_reg ? -y_it : y_it;
            end
        end
    end

    // reset state is a run for angle zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b1;
            step_reg    <= '0;
            x_reg       <= CORDIC_GAIN;
            y_reg       <= '0;
            z_reg       <= '0;
            flip_reg    <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            step_reg    <= step_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            z_reg       <= z_next;
            flip_reg    <= flip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        trig_reg <= trig_next;
    end

    assign busy = running_reg;
    assign trig = trig_reg;

endmodule

### rtl/pat_datapath.sv
// ----------------------------------------------------------------------------
// pat_datapath
// Three-stage point pipeline: offsets and coefficients, products, round and
// saturate.
// ----------------------------------------------------------------------------
module pat_datapath
    import pat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  pat_in_t   point,
    input  pat_cfg_t  cfg,
    input  pat_trig_t trig,
    output logic      done,
    output pat_out_t  result
);

    localparam logic signed [SW-1:0] HALF_TRIG = SW'(64'sd1 <<< (TRIG_FRAC - 1));
    localparam logic signed [SW-1:0] HALF_FRAC = SW'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

    // stage 1
    logic                 v1_reg;
    logic [ID_W-1:0]      id1_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg, bx1_reg, by1_reg;
    logic signed [KW-1:0] kxa1_reg, kxb1_reg, kya1_reg, kyb1_reg;
    logic                 bad1_reg, rot1_reg;
    logic signed [DW-1:0] dx1_next, dy1_next, bx1_next, by1_next, ux, uy;
    logic signed [KW-1:0] kxa1_next, kxb1_next, kya1_next, kyb1_next;
    logic                 bad1_next;

    // stage 2
    logic                 v2_reg;
    logic [ID_W-1:0]      id2_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [DW-1:0] bx2_reg, by2_reg;
    logic                 bad2_reg, rot2_reg;

    // stage 3
    logic                 v3_reg;
    pat_out_t             out_reg, out_next;
    logic signed [SW-1:0] sx, sy, hx, hy, rx, ry, half;
    logic signed [FW-1:0] fx, fy;
    logic                 sat_x, sat_y;

    always_comb
    begin
        dx1_next = DW'(point.x_in) - DW'(cfg.pivot_x);
        dy1_next = DW'(point.y_in) - DW'(cfg.pivot_y);
        ux       = DW'(cfg.end_x) - DW'(cfg.first_x);
        uy       = DW'(cfg.end_y) - DW'(cfg.first_y);
        bx1_next = DW'(cfg.pivot_x);
        by1_next = DW'(cfg.pivot_y);
        kxa1_next = '0;
        kxb1_next = '0;
        kya1_next = '0;
        kyb1_next = '0;
        bad1_next = 1'b0;
        // x' = base + dx*kxa - dy*kxb, y' = base + dx*kya + dy*kyb
        case (cfg.mode)
            MODE_TRANSLATE:
            begin
                bx1_next = DW'(point.x_in) + DW'(cfg.first_x);
                by1_next = DW'(point.y_in) + DW'(cfg.first_y);
            end
            MODE_ROTATE:
            begin
                kxa1_next = KW'(trig.cos_val);
                kxb1_next = KW'(trig.sin_val);
                kya1_next = KW'(trig.sin_val);
                kyb1_next = KW'(trig.cos_val);
            end
            MODE_SCALE:
            begin
                kxa1_next = KW'(cfg.first_x);
                kyb1_next = KW'(cfg.first_y);
                bad1_next = (cfg.first_x == '0) || (cfg.first_y == '0);
            end
            MODE_MAP:
            begin
                bx1_next  = DW'(cfg.first_x);
                by1_next  = DW'(cfg.first_y);
                kxa1_next = KW'(ux);
                kxb1_next = KW'(uy);
                kya1_next = KW'(uy);
                kyb1_next = KW'(ux);
                bad1_next = (ux == '0) && (uy == '0);
            end
            default:
            begin
                bad1_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        sx   = SW'(p0_reg) - SW'(p1_reg);
        sy   = SW'(p2_reg) + SW'(p3_reg);
        half = rot2_reg ? HALF_TRIG : HALF_FRAC;
        hx   = sx + half;
        hy   = sy + half;
        rx   = rot2_reg ? (hx >>> TRIG_FRAC) : (hx >>> FRAC_BITS);
        ry   = rot2_reg ? (hy >>> TRIG_FRAC) : (hy >>> FRAC_BITS);
        fx   = FW'(bx2_reg) + FW'(rx);
        fy   = FW'(by2_reg) + FW'(ry);

        sat_x = (fx > FW'(MAXV)) || (fx < FW'(MINV));
        sat_y = (fy > FW'(MAXV)) || (fy < FW'(MINV));

        out_next.id_out = id2_reg;
        if (bad2_reg)
        begin
            out_next.x_out  = '0;
            out_next.y_out  = '0;
            out_next.status = STATUS_SETUP_ERR;
        end
        else
        begin
            out_next.x_out  = sat_x ? (fx[FW-1] ? MINV : MAXV) : fx[COORD_WIDTH-1:0];
            out_next.y_out  = sat_y ? (fy[FW-1] ? MINV : MAXV) : fy[COORD_WIDTH-1:0];
            out_next.status = (sat_x || sat_y) ? STATUS_SAT : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id1_reg  <= point.point_id;
            dx1_reg  <= dx1_next;
            dy1_reg  <= dy1_next;
            bx1_reg  <= bx1_next;
            by1_reg  <= by1_next;
            kxa1_reg <= kxa1_next;
            kxb1_reg <= kxb1_next;
            kya1_reg <= kya1_next;
            kyb1_reg <= kyb1_next;
            bad1_reg <= bad1_next;
            rot1_reg <= (cfg.mode == MODE_ROTATE);
        end
        if (v1_reg)
        begin
            id2_reg  <= id1_reg;
            p0_reg   <= dx1_reg * kxa1_reg;
            p1_reg   <= dy1_reg * kxb1_reg;
            p2_reg   <= dx1_reg * kya1_reg;
            p3_reg   <= dy1_reg * kyb1_reg;
            bx2_reg  <= bx1_reg;
            by2_reg  <= by1_reg;
            bad2_reg <= bad1_reg;
            rot2_reg <= rot1_reg;
        end
        if (v2_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign done   = v3_reg;
    assign result = out_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for point_affine_transform_unit. Directed tests cover
// reset values, each mode, saturation and setup errors; random traffic then
// sweeps register settings. Every accepted point is predicted in the bench
// and compared field by field with the result strobed out on done.
// ----------------------------------------------------------------------------
module tb_top;

    import pat_pkg::*;

    localparam int RANDOM_POINTS = 1900;
    localparam int PIPE_DEPTH    = 3;
    localparam int CORDIC_ITERS  =
        (CORDIC_STEPS_DEFAULT < ATAN_ENTRIES) ? CORDIC_STEPS_DEFAULT : ATAN_ENTRIES;

    localparam logic signed [127:0] WIDE_ONE  = 128'sd1;
    localparam logic signed [127:0] COORD_MAX = (WIDE_ONE <<< (COORD_WIDTH - 1)) - 1;
    localparam logic signed [127:0] COORD_MIN = -COORD_MAX - 1;

    // atan(2^-i) in 2^-32 turn, entry 0 in the top word
    localparam logic [ATAN_ENTRIES*32-1:0] ATAN_LUT = {
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    pat_in_t               point;
    logic                  done;
    pat_out_t              result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // register shadow used by the predictor
    pat_cfg_t           cfg_shadow;
    logic [ANGLE_W-1:0] angle_shadow;

    pat_out_t transformed_points[$];
    pat_out_t want;

    int  mismatches    = 0;
    int  results_seen  = 0;
    int  points_sent   = 0;
    int  setups        = 0;
    int  sat_points    = 0;
    int  setup_errs    = 0;
    int  mode_points[4] = '{0, 0, 0, 0};
    int  burst_left    = 0;
    logic gaps_on      = 1'b1;

    point_affine_transform_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic logic signed [127:0] round_shift(input logic signed [127:0] v,
                                                        input int sh);
        return (v + (WIDE_ONE <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] clamp_coord(input logic signed [127:0] v,
                                                           inout logic clipped);
        if (v > COORD_MAX)
        begin
            clipped = 1'b1;
            return COORD_MAX[COORD_WIDTH-1:0];
        end
        if (v < COORD_MIN)
        begin
            clipped = 1'b1;
            return COORD_MIN[COORD_WIDTH-1:0];
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    // cosine and sine in Q2.30
    function automatic void cordic_trig(input logic [ANGLE_W-1:0] turn,
                                        output longint cos_q30, output longint sin_q30);
        logic [ANGLE_W-1:0] a;
        logic               flip;
        longint             x, y, z, nx, ny, step_turn;
        a = turn;
        // second and third quadrant: rotate by angle - 180 and negate
        flip = (a[15:14] == 2'b01) || (a[15:14] == 2'b10);
        if (flip)
            a = a ^ 16'h8000;
        z = longint'($signed(a)) * 65536;
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            step_turn = longint'(ATAN_LUT[(ATAN_ENTRIES - 1 - i) * 32 +: 32]);
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - step_turn;
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + step_turn;
            end
            x = nx;
            y = ny;
        end
        cos_q30 = flip ? -x : x;
        sin_q30 = flip ? -y : y;
    endfunction

    function automatic pat_out_t transform_point(input pat_in_t p);
        logic signed [127:0] px, py, dx, dy, rx, ry, ux, uy, kc, ks;
        logic signed [127:0] fx, fy, pvx, pvy, ex, ey;
        longint              cos_q30, sin_q30;
        logic                bad;
        logic                clipped;
        pat_out_t            r;
        px  = $signed(p.x_in);
        py  = $signed(p.y_in);
        fx  = $signed(cfg_shadow.first_x);
        fy  = $signed(cfg_shadow.first_y);
        pvx = $signed(cfg_shadow.pivot_x);
        pvy = $signed(cfg_shadow.pivot_y);
        ex  = $signed(cfg_shadow.end_x);
        ey  = $signed(cfg_shadow.end_y);
        dx  = px - pvx;
        dy  = py - pvy;
        bad = 1'b0;
        case (cfg_shadow.mode)
            MODE_TRANSLATE:
            begin
                rx = px + fx;
                ry = py + fy;
            end
            MODE_ROTATE:
            begin
                cordic_trig(angle_shadow, cos_q30, sin_q30);
                kc = cos_q30;
                ks = sin_q30;
                rx = pvx + round_shift(dx * kc - dy * ks, TRIG_FRAC);
                ry = pvy + round_shift(dx * ks + dy * kc, TRIG_FRAC);
            end
            MODE_SCALE:
            begin
                bad = (fx == 0) || (fy == 0);
                rx  = pvx + round_shift(dx * fx, FRAC_BITS);
                ry  = pvy + round_shift(dy * fy, FRAC_BITS);
            end
            default:
            begin
                ux  = ex - fx;
                uy  = ey - fy;
                bad = (ux == 0) && (uy == 0);
                rx  = fx + round_shift(dx * ux - dy * uy, FRAC_BITS);
                ry  = fy + round_shift(dx * uy + dy * ux, FRAC_BITS);
            end
        endcase
        r.id_out = p.point_id;
        if (bad)
        begin
            r.x_out  = '0;
            r.y_out  = '0;
            r.status = STATUS_SETUP_ERR;
        end
        else
        begin
            clipped  = 1'b0;
            r.x_out  = clamp_coord(rx, clipped);
            r.y_out  = clamp_coord(ry, clipped);
            r.status = clipped ? STATUS_SAT : STATUS_OK;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (transformed_points.size() == 0)
            begin
                $error("unexpected result transaction, id %0h", result.id_out);
                mismatches++;
            end
            else
            begin
                want = transformed_points.pop_front();
                if (result.id_out !== want.id_out)
                begin
                    $error("id_out: expected %0h, actual %0h", want.id_out, result.id_out);
                    mismatches++;
                end
                if (result.x_out !== want.x_out)
                begin
                    $error("x_out: expected %0d, actual %0d", want.x_out, result.x_out);
                    mismatches++;
                end
                if (result.y_out !== want.y_out)
                begin
                    $error("y_out: expected %0d, actual %0d", want.y_out, result.y_out);
                    mismatches++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, result.status);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_point(input logic [ID_W-1:0] id,
                              input logic [COORD_WIDTH-1:0] x,
                              input logic [COORD_WIDTH-1:0] y);
        pat_in_t  item;
        pat_out_t expected;
        int       gap;
        item.point_id = id;
        item.x_in     = x;
        item.y_in     = y;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        point <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected = transform_point(item);
        transformed_points = {transformed_points, expected};
        points_sent++;
        mode_points[cfg_shadow.mode]++;
        if (expected.status == STATUS_SAT)
            sat_points++;
        if (expected.status == STATUS_SETUP_ERR)
            setup_errs++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (transformed_points.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    task automatic write_reg(input pat_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_MODE:    cfg_shadow.mode    = pat_mode_t'(data[1:0]);
            CFG_FIRST_X: cfg_shadow.first_x = data;
            CFG_FIRST_Y: cfg_shadow.first_y = data;
            CFG_ANGLE:   angle_shadow       = data[ANGLE_W-1:0];
            CFG_PIVOT_X: cfg_shadow.pivot_x = data;
            CFG_PIVOT_Y: cfg_shadow.pivot_y = data;
            CFG_END_X:   cfg_shadow.end_x   = data;
            default:     cfg_shadow.end_y   = data;
        endcase
    endtask

    // waits for the pipeline to empty, then rewrites every register
    task automatic apply_setup(input pat_mode_t mode,
                               input logic [31:0] fx, input logic [31:0] fy,
                               input logic [ANGLE_W-1:0] angle,
                               input logic [31:0] pvx, input logic [31:0] pvy,
                               input logic [31:0] ex, input logic [31:0] ey);
        logic [31:0] junk;
        junk = $urandom;
        drain_results();
        // upper bits of the narrow registers must be ignored
        write_reg(CFG_MODE, {junk[31:2], mode});
        write_reg(CFG_FIRST_X, fx);
        write_reg(CFG_FIRST_Y, fy);
        write_reg(CFG_ANGLE, {junk[15:0], angle});
        write_reg(CFG_PIVOT_X, pvx);
        write_reg(CFG_PIVOT_Y, pvy);
        write_reg(CFG_END_X, ex);
        write_reg(CFG_END_Y, ey);
        cfg_we <= 1'b0;
        setups++;
    endtask

    // ------------------------------------------------------------------------
    // random values
    // ------------------------------------------------------------------------
    function automatic logic [31:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return r;
            3:       return {{8{r[23]}}, r[23:0]};
            4:       return {{28{r[3]}}, r[3:0]};
            default: return {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    function automatic logic [31:0] rand_factor();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return r;
            default: return {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_values();
        // all registers reset to zero: translate by nothing
        send_point(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_translate();
        apply_setup(MODE_TRANSLATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0,
                    32'h0, 32'h0, 32'h0, 32'h0);
        send_point(16'h0001, 32'h0000_0000, 32'h0000_0000);
        send_point(16'h1234, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(16'hABCD, 32'hFFFF_FFFF, 32'h0000_0001);
    endtask

    task automatic test_rotate();
        logic [ANGLE_W-1:0] turns [0:5];
        turns = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
        foreach (turns[i])
        begin
            apply_setup(MODE_ROTATE, $urandom, $urandom, turns[i],
                        32'h0000_4000, 32'hFFFF_4000, $urandom, $urandom);
            send_point(ID_W'(16'h0100 + i), 32'h0001_0000, 32'h0000_8000);
        end
        // far corner around an opposite pivot overflows
        apply_setup(MODE_ROTATE, 32'h0, 32'h0, 16'h2000,
                    32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        send_point(16'h0200, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    endtask

    task automatic test_scale();
        apply_setup(MODE_SCALE, 32'h0, 32'h0002_0000, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_point(16'h0300, 32'h0001_0000, 32'h0001_0000);
        apply_setup(MODE_SCALE, 32'h0002_0000, 32'h0, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_point(16'h0301, 32'h0001_0000, 32'h0001_0000);
        apply_setup(MODE_SCALE, 32'h0002_0000, 32'hFFFF_8000, 16'h0,
                    32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_point(16'h0302, 32'h0003_8000, 32'hFFFE_0001);
        send_point(16'h0303, 32'h0000_0001, 32'h0000_0003);
        apply_setup(MODE_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0,
                    32'h0, 32'h0, 32'h0, 32'h0);
        send_point(16'h0304, 32'h8000_0000, 32'h7FFF_FFFF);
    endtask

    task automatic test_map();
        // zero-length segment
        apply_setup(MODE_MAP, 32'h0003_0000, 32'hFFFE_0000, 16'h0,
                    32'h0, 32'h0, 32'h0003_0000, 32'hFFFE_0000);
        send_point(16'h0400, 32'h0001_0000, 32'h0002_0000);
        apply_setup(MODE_MAP, 32'h0001_0000, 32'h0002_0000, 16'h0,
                    32'h0000_8000, 32'hFFFF_C000, 32'h0003_0000, 32'h0002_8000);
        send_point(16'h0401, 32'h0000_8000, 32'h0000_4000);
        send_point(16'h0402, 32'hFFFF_0001, 32'h0002_C000);
        apply_setup(MODE_MAP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0,
                    32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000);
        send_point(16'h0403, 32'h7FFF_FFFF, 32'h8000_0000);
    endtask

    task automatic test_random_traffic();
        pat_mode_t   mode;
        logic [31:0] fx, fy, pvx, pvy, ex, ey;
        int          batch;
        int          sent_here;
        sent_here = 0;
        while (sent_here < RANDOM_POINTS)
        begin
            mode = pat_mode_t'($urandom_range(0, 3));
            fx   = (mode == MODE_SCALE) ? rand_factor() : rand_coord();
            fy   = (mode == MODE_SCALE) ? rand_factor() : rand_coord();
            pvx  = rand_coord();
            pvy  = rand_coord();
            ex   = rand_coord();
            ey   = rand_coord();
            if (mode == MODE_MAP && $urandom_range(0, 7) == 0)
            begin
                ex = fx;
                ey = fy;
            end
            apply_setup(mode, fx, fy, ANGLE_W'($urandom_range(0, 65535)), pvx, pvy, ex, ey);
            gaps_on = ($urandom_range(0, 3) != 0);
            batch   = $urandom_range(8, 60);
            repeat (batch)
                send_point(ID_W'($urandom_range(0, 65535)), rand_coord(), rand_coord());
            sent_here += batch;
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        point        <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_MODE;
        cfg_data     <= '0;
        cfg_shadow   = '0;
        angle_shadow = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_translate();
        test_rotate();
        test_scale();
        test_map();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge clk);
        $display("covered %0d points over %0d setups: %0d translate, %0d rotate",
                 points_sent, setups, mode_points[0], mode_points[1]);
        $display("%0d scale, %0d map, %0d results checked, %0d saturated, %0d setup errors",
                 mode_points[2], mode_points[3], results_seen, sat_points, setup_errs);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("timeout waiting for result transactions");
        $display("tb_top failed");
        $finish;
    end

endmodule

### point_affine_transform_unit.f
rtl/pat_pkg.sv
rtl/pat_cordic.sv
rtl/pat_datapath.sv
rtl/point_affine_transform_unit.sv
tb/tb_top.sv
